// File: design/ctcgd_pkg.sv
// Shared constants and the exp table builder for the CTC greedy decoder.
// No dependencies.
package ctcgd_pkg;

   localparam int unsigned CLASS_INDEX_BITS_DEF = 16;
   localparam int unsigned EXP_TABLE_DEPTH_DEF  = 256;
   localparam int unsigned EXP_W                = 17;  // entries reach 65536
   localparam int unsigned DATA_W               = 56;  // 49 payload bits, byte padded

   localparam logic [0:0] KIND_CHAR    = 1'b0;
   localparam logic [0:0] KIND_SUMMARY = 1'b1;

   localparam logic [15:0] DICT_SIZE_RST = 16'hFFFF;
   localparam logic        REG_DICT_SIZE = 1'b0;   // paddr[2] for dictionary_size

   // Entry k of 65536*exp(-16k/depth), integer Taylor step in Q2.30.
   function automatic logic [EXP_W-1:0] exp_entry(input int unsigned k,
                                                   input int unsigned depth);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] f;
      logic [63:0] e;
      x    = (64'd16 << 30) / 64'(depth);
      term = 64'd1 << 30;
      pos  = 64'd1 << 30;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * x) >> 30) / 64'(n);
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      f = pos - neg;
      e = 64'd1 << 30;
      for (int unsigned i = 1; i <= k; i++) begin
         e = (e * f + (64'd1 << 29)) >> 30;
      end
      e = (e + (64'd1 << 13)) >> 14;
      return e[EXP_W-1:0];
   endfunction

endpackage

// File: design/ctc_greedy_decoder.sv
// CTC greedy decoder top level: argmax, online softmax, shared divider.
// Depends on ctcgd_pkg.
//
// Usage: class scores (signed Q8.8) arrive on the req_ stream one beat per
// class; tuser[0] = row end, tuser[1] = sequence end (which also ends the
// row). Results leave on the rsp_ stream: tuser = result kind (0 character,
// 1 sequence summary), tlast = last result caused by that input beat.
// Steps: a score that does not end a row passes the table lookup, then the
// 32x17 rescale multiply. A row end adds the row check and the emit, plus a
// run of the shared restoring divider when the row is a logit row
// (2^32 / softmax sum). A sequence end adds the average setup and the
// summary, plus another divider run when any character was emitted.
// The divider and the single-beat output register set the rate;
// req_tready is high only in the idle state.
// If the receiver stalls, the block holds the finished result in the output
// register and waits in the emitting state before taking more input.
// Reset (synchronous) clears the row and sequence state, the output valid,
// and sets dictionary_size to 65535. The exp table is constant logic.
module ctc_greedy_decoder #(
   parameter int unsigned CLASS_INDEX_BITS = ctcgd_pkg::CLASS_INDEX_BITS_DEF,
   parameter int unsigned EXP_TABLE_DEPTH  = ctcgd_pkg::EXP_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] score
   input  logic [1:0]  req_tuser,   // [0] row_end, [1] sequence_end
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [ctcgd_pkg::DATA_W-1:0] rsp_tdata, // [15:0] symbol_index,
                                   // [16] in_dictionary, [32:17] confidence,
                                   // [48:33] symbol_count, [55:49] zero
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast,   // last
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned CIB   = CLASS_INDEX_BITS;
   localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int unsigned EW    = ctcgd_pkg::EXP_W;
   localparam logic [CIB-1:0] POS_MAX = {CIB{1'b1}};

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_ACC  = 7'b0000010,
      S_ROW  = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_CHAR = 7'b0010000,
      S_AVG  = 7'b0100000,
      S_SUM  = 7'b1000000
   } state_type;

   // constant exp table
   logic [EW-1:0] exp_rom [EXP_TABLE_DEPTH];
   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [EW-1:0] V = ctcgd_pkg::exp_entry(g, EXP_TABLE_DEPTH);
      assign exp_rom[g] = V;
   end

   state_type state_ff, state_in;

   logic [15:0]     dict_ff, dict_in;
   logic signed [15:0] best_ff, best_in;
   logic [CIB-1:0]  winner_ff, winner_in;
   logic [CIB-1:0]  pos_ff, pos_in;
   logic [31:0]     smsum_ff, smsum_in;
   logic [CIB-1:0]  prev_ff, prev_in;
   logic            prev_vld_ff, prev_vld_in;
   logic [31:0]     csum_ff, csum_in;
   logic [15:0]     count_ff, count_in;

   logic signed [15:0] score_ff, score_in;
   logic [EW-1:0]   e_ff, e_in;
   logic            gt_ff, gt_in;
   logic            rend_ff, rend_in;
   logic            send_ff, send_in;
   logic [15:0]     conf_ff, conf_in;

   // shared divider
   logic [32:0]     dn_ff, dn_in;
   logic [31:0]     dd_ff, dd_in;
   logic [31:0]     rem_ff, rem_in;
   logic [32:0]     q_ff, q_in;
   logic [5:0]      dcnt_ff, dcnt_in;
   logic            davg_ff, davg_in;

   // output register
   logic            ov_ff, ov_in;
   logic [ctcgd_pkg::DATA_W-1:0] od_ff, od_in;
   logic            ok_ff, ok_in;
   logic            ol_ff, ol_in;

   // combinational helpers
   logic signed [16:0] diff;
   logic [15:0]     dmag;
   logic [12:0]     dcl;
   logic [31:0]     idx_full;
   logic [IDX_W-1:0] idx;
   logic            s_gt;
   logic [48:0]     prod;
   logic [33:0]     rescaled;
   logic [32:0]     addsum;
   logic [32:0]     rtry;
   logic            rge;
   logic [32:0]     qnext;
   logic            out_free;
   logic            emit;
   logic [31:0]     sym;
   logic [32:0]     csum_add;
   logic [15:0]     count_inc;
   logic            cfg_wr;

   assign out_free = !ov_ff || rsp_tready;
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      // score path: difference to the row best, clamp, table index
      s_gt     = $signed(req_tdata) > best_ff;
      diff     = s_gt ? (17'($signed(req_tdata)) - 17'(best_ff))
                      : (17'(best_ff) - 17'($signed(req_tdata)));
      dmag     = diff[15:0];
      dcl      = (dmag > 16'd4096) ? 13'd4096 : dmag[12:0];
      idx_full = (32'(dcl) * 32'(EXP_TABLE_DEPTH)) >> 12;
      idx      = (idx_full > 32'(EXP_TABLE_DEPTH - 1)) ? IDX_W'(EXP_TABLE_DEPTH - 1)
                                                       : idx_full[IDX_W-1:0];
      // softmax update, one multiply
      prod     = 49'(smsum_ff) * 49'(e_ff);
      rescaled = 34'(prod[48:16]) + 34'd65536;
      addsum   = 33'(smsum_ff) + 33'(e_ff);
      // divider step
      rtry     = {rem_ff, dn_ff[32]};
      rge      = rtry >= 33'(dd_ff);
      qnext    = {q_ff[31:0], rge};
      // character decision
      emit      = (winner_ff != '0) && (!prev_vld_ff || winner_ff != prev_ff);
      sym       = 32'(winner_ff) - 32'd1;
      csum_add  = 33'(csum_ff) + 33'(conf_ff);
      count_inc = (count_ff != 16'hFFFF) ? count_ff + 16'd1 : count_ff;
   end

   always_comb begin
      state_in    = state_ff;
      dict_in     = dict_ff;
      best_in     = best_ff;
      winner_in   = winner_ff;
      pos_in      = pos_ff;
      smsum_in    = smsum_ff;
      prev_in     = prev_ff;
      prev_vld_in = prev_vld_ff;
      csum_in     = csum_ff;
      count_in    = count_ff;
      score_in    = score_ff;
      e_in        = e_ff;
      gt_in       = gt_ff;
      rend_in     = rend_ff;
      send_in     = send_ff;
      conf_in     = conf_ff;
      dn_in       = dn_ff;
      dd_in       = dd_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      dcnt_in     = dcnt_ff;
      davg_in     = davg_ff;
      ov_in       = ov_ff && !rsp_tready;
      od_in       = od_ff;
      ok_in       = ok_ff;
      ol_in       = ol_ff;

      if (cfg_wr && csr_paddr[2] == ctcgd_pkg::REG_DICT_SIZE) begin
         dict_in = csr_pwdata[15:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               score_in = $signed(req_tdata);
               e_in     = exp_rom[idx];
               gt_in    = s_gt;
               rend_in  = req_tuser[0] || req_tuser[1];
               send_in  = req_tuser[1];
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (gt_ff) begin
               smsum_in  = (rescaled > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : rescaled[31:0];
               best_in   = score_ff;
               winner_in = pos_ff;
            end else begin
               smsum_in  = addsum[32] ? 32'hFFFF_FFFF : addsum[31:0];
            end
            if (pos_ff != POS_MAX) pos_in = pos_ff + CIB'(1);
            state_in = rend_ff ? S_ROW : S_IDLE;
         end
         S_ROW: begin
            if (best_ff >= 16'sd0 && best_ff <= 16'sd256) begin
               // probability row: scale Q8.8 to Q0.16
               conf_in  = (best_ff == 16'sd256) ? 16'hFFFF : {best_ff[7:0], 8'h00};
               state_in = S_CHAR;
            end else if (smsum_ff == '0) begin
               conf_in  = 16'hFFFF;
               state_in = S_CHAR;
            end else begin
               dn_in    = 33'h1_0000_0000;
               dd_in    = smsum_ff;
               rem_in   = '0;
               q_in     = '0;
               dcnt_in  = '0;
               davg_in  = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = rge ? 32'(rtry - 33'(dd_ff)) : rtry[31:0];
            dn_in   = {dn_ff[31:0], 1'b0};
            q_in    = qnext;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd32) begin
               conf_in  = (qnext > 33'hFFFF) ? 16'hFFFF : qnext[15:0];
               state_in = davg_ff ? S_SUM : S_CHAR;
            end
         end
         S_CHAR: begin
            if (!emit || out_free) begin
               if (emit) begin
                  ov_in    = 1'b1;
                  ok_in    = ctcgd_pkg::KIND_CHAR;
                  ol_in    = !send_ff;
                  od_in    = {7'd0, count_inc, conf_ff, (sym < 32'(dict_ff)), sym[15:0]};
                  csum_in  = csum_add[32] ? 32'hFFFF_FFFF : csum_add[31:0];
                  count_in = count_inc;
               end
               prev_in     = winner_ff;
               prev_vld_in = 1'b1;
               best_in     = 16'sh8000;
               winner_in   = '0;
               pos_in      = '0;
               smsum_in    = '0;
               state_in    = send_ff ? S_AVG : S_IDLE;
            end
         end
         S_AVG: begin
            if (count_ff == '0) begin
               conf_in  = '0;
               state_in = S_SUM;
            end else begin
               dn_in    = {1'b0, csum_ff};
               dd_in    = 32'(count_ff);
               rem_in   = '0;
               q_in     = '0;
               dcnt_in  = '0;
               davg_in  = 1'b1;
               state_in = S_DIV;
            end
         end
         S_SUM: begin
            if (out_free) begin
               ov_in       = 1'b1;
               ok_in       = ctcgd_pkg::KIND_SUMMARY;
               ol_in       = 1'b1;
               od_in       = {7'd0, count_ff, conf_ff, 1'b0, 16'd0};
               prev_in     = '0;
               prev_vld_in = 1'b0;
               csum_in     = '0;
               count_in    = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         dict_ff     <= ctcgd_pkg::DICT_SIZE_RST;
         best_ff     <= 16'sh8000;
         winner_ff   <= '0;
         pos_ff      <= '0;
         smsum_ff    <= '0;
         prev_ff     <= '0;
         prev_vld_ff <= 1'b0;
         csum_ff     <= '0;
         count_ff    <= '0;
         dcnt_ff     <= '0;
         davg_ff     <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dict_ff     <= dict_in;
         best_ff     <= best_in;
         winner_ff   <= winner_in;
         pos_ff      <= pos_in;
         smsum_ff    <= smsum_in;
         prev_ff     <= prev_in;
         prev_vld_ff <= prev_vld_in;
         csum_ff     <= csum_in;
         count_ff    <= count_in;
         dcnt_ff     <= dcnt_in;
         davg_ff     <= davg_in;
         ov_ff       <= ov_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      score_ff <= score_in;
      e_ff     <= e_in;
      gt_ff    <= gt_in;
      rend_ff  <= rend_in;
      send_ff  <= send_in;
      conf_ff  <= conf_in;
      dn_ff    <= dn_in;
      dd_ff    <= dd_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      od_ff    <= od_in;
      ok_ff    <= ok_in;
      ol_ff    <= ol_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tlast  = ol_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ctcgd_pkg::REG_DICT_SIZE) ? {16'd0, dict_ff} : 32'd0;

   // a summary always closes the beats of its input
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ctcgd_pkg::KIND_SUMMARY |-> rsp_tlast)
      else $error("summary without tlast");

   // a character result always counts itself
   a_char_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ctcgd_pkg::KIND_CHAR |-> rsp_tdata[48:33] != 16'd0)
      else $error("character with zero count");

   // the divider step counter never passes 32 inside the divide state
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dcnt_ff <= 6'd32)
      else $error("divider step count overrun");

   // input is taken only while no row or sequence work is pending
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_ACC)
      else $error("accept did not start accumulation");

endmodule

// File: dv/tb.sv
// Self-checking testbench for ctc_greedy_decoder: queued score beats, a
// predictor of argmax, online softmax and emission, and an in-order checker.
// Depends on ctcgd_pkg and ctc_greedy_decoder.
module tb;

   localparam int unsigned DEPTH    = ctcgd_pkg::EXP_TABLE_DEPTH_DEF;
   localparam int unsigned POS_MAX  = (1 << ctcgd_pkg::CLASS_INDEX_BITS_DEF) - 1;
   localparam int          WATCHDOG = 20000;

   typedef struct packed {
      logic signed [15:0] score;
      logic               row_end;
      logic               seq_end;
   } score_beat_type;

   typedef struct packed {
      logic [0:0]  kind;
      logic [15:0] symbol;
      logic        in_dict;
      logic [15:0] conf;
      logic [15:0] count;
      logic        last;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [ctcgd_pkg::DATA_W-1:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ctc_greedy_decoder DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [16:0]        exp_lut [DEPTH];
   logic [15:0]        dict_size;
   logic signed [31:0] row_top;
   int unsigned        best_class, class_pos, prev_class, conf_total, char_count;
   logic [31:0]        softmax_acc;
   bit                 prev_known;

   score_beat_type    pending_beats[$];
   decode_result_type expected_results[$];
   int  errors = 0, sent_beats = 0, got_results = 0, idle_cycles = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  stimulus_done = 0;
   bit  accepted_last = 0;

   function automatic logic [31:0] sat_u32(longint unsigned v);
      return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // exp(-d) from the table, d in Q8.8, clamped to 16.0
   function automatic logic [16:0] exp_of_gap(int unsigned d);
      int unsigned k;
      if (d > 4096) d = 4096;
      k = d * DEPTH / 4096;
      if (k > DEPTH - 1) k = DEPTH - 1;
      return exp_lut[k];
   endfunction

   function automatic void decoder_reset_state();
      dict_size   = ctcgd_pkg::DICT_SIZE_RST;
      row_top     = -32768; best_class = 0; class_pos = 0; softmax_acc = 0;
      prev_class  = 0; prev_known = 0; conf_total = 0; char_count = 0;
   endfunction

   function automatic void predict_decode(score_beat_type b);
      longint unsigned scaled, quot;
      int unsigned conf, avg, sym;
      decode_result_type r;
      if (b.score > row_top) begin
         scaled = (longint'(softmax_acc) * exp_of_gap(b.score - row_top)) >> 16;
         softmax_acc = sat_u32(scaled + 65536);
         row_top = b.score;
         best_class = class_pos;
      end else begin
         softmax_acc = sat_u32(longint'(softmax_acc) + exp_of_gap(row_top - b.score));
      end
      if (class_pos < POS_MAX) class_pos++;
      if (b.row_end || b.seq_end) begin
         if (row_top >= 0 && row_top <= 256) begin
            conf = row_top * 256;
            if (conf > 65535) conf = 65535;
         end else if (softmax_acc == 0) conf = 65535;
         else begin
            quot = (64'd1 << 32) / softmax_acc;
            conf = (quot > 65535) ? 32'd65535 : quot[31:0];
         end
         // blank and repeated winners emit nothing
         if (best_class != 0 && (!prev_known || best_class != prev_class)) begin
            sym = best_class - 1;
            conf_total = sat_u32(longint'(conf_total) + conf);
            if (char_count < 65535) char_count++;
            r.kind = ctcgd_pkg::KIND_CHAR; r.symbol = sym[15:0];
            r.in_dict = (sym < 32'(dict_size)); r.conf = conf[15:0];
            r.count = char_count[15:0]; r.last = !b.seq_end;
            expected_results = {expected_results, r};
         end
         prev_class = best_class; prev_known = 1;
         row_top = -32768; best_class = 0; class_pos = 0; softmax_acc = 0;
      end
      if (b.seq_end) begin
         avg = char_count ? conf_total / char_count : 0;
         if (avg > 65535) avg = 65535;
         r.kind = ctcgd_pkg::KIND_SUMMARY; r.symbol = '0; r.in_dict = 0;
         r.conf = avg[15:0]; r.count = char_count[15:0]; r.last = 1;
         expected_results = {expected_results, r};
         prev_class = 0; prev_known = 0; conf_total = 0; char_count = 0;
      end
   endfunction

   // driver: a beat leaves the queue at the edge it is accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || accepted_last) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_beats[0].score;
               req_tuser  <= {pending_beats[0].seq_end, pending_beats[0].row_end};
            end else req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      accepted_last <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            predict_decode(pending_beats.pop_front());
            sent_beats   <= sent_beats + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            decode_result_type exp_r;
            got_results <= got_results + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result beat kind=%0d data=%h", rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tuser !== exp_r.kind) begin
                  $error("result_kind exp %0d got %0d", exp_r.kind, rsp_tuser); errors++; end
               if (rsp_tdata[15:0] !== exp_r.symbol) begin
                  $error("symbol_index exp %0d got %0d", exp_r.symbol, rsp_tdata[15:0]);
                  errors++; end
               if (rsp_tdata[16] !== exp_r.in_dict) begin
                  $error("in_dictionary exp %0d got %0d", exp_r.in_dict, rsp_tdata[16]);
                  errors++; end
               if (rsp_tdata[32:17] !== exp_r.conf) begin
                  $error("confidence exp %0d got %0d", exp_r.conf, rsp_tdata[32:17]);
                  errors++; end
               if (rsp_tdata[48:33] !== exp_r.count) begin
                  $error("symbol_count exp %0d got %0d", exp_r.count, rsp_tdata[48:33]);
                  errors++; end
               if (rsp_tlast !== exp_r.last) begin
                  $error("last exp %0d got %0d", exp_r.last, rsp_tlast); errors++; end
            end
         end
         if (idle_cycles > WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_beats.size() > 0 || expected_results.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (100) @(posedge clock);   // a row with no result may still be dividing
   endtask

   task automatic csr_write(logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {ctcgd_pkg::REG_DICT_SIZE, 2'b00};
      csr_pwdata <= {16'h0, value};
      @(negedge clock); csr_penable <= 1;
      @(negedge clock); csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      dict_size = value;
   endtask

   function automatic void push_beat(int score, bit re, bit se);
      score_beat_type b;
      b.score = score[15:0]; b.row_end = re; b.seq_end = se;
      pending_beats = {pending_beats, b};
   endfunction

   // well-formed sequence: random rows, mostly logits, some probabilities
   function automatic void push_sequence(int rows, int classes);
      bit prob;
      int s;
      for (int r = 0; r < rows; r++) begin
         prob = ($urandom_range(3) == 0);
         for (int c = 0; c < classes; c++) begin
            case ($urandom_range(9))
               0: s = $urandom_range(65535) - 32768;
               1: s = 32767;
               default: s = prob ? $urandom_range(256) : $urandom_range(2000) - 1000;
            endcase
            if (c == classes - 1) push_beat(s, (r != rows - 1) | 1'($urandom_range(1)),
                                            r == rows - 1);
            else push_beat(s, 0, 0);
         end
      end
   endfunction

   initial begin
      decoder_reset_state();
      for (int k = 0; k < DEPTH; k++) exp_lut[k] = ctcgd_pkg::exp_entry(k, DEPTH);
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed: extremes, blank, repeat, probability row, sums of nothing
      push_beat(-32768, 0, 0); push_beat(32767, 1, 0);    // class 1 wins
      push_beat(0, 0, 0); push_beat(32767, 1, 0);          // repeat, no char
      push_beat(300, 0, 0); push_beat(-32768, 1, 0);       // blank wins
      push_beat(0, 0, 0); push_beat(256, 0, 0); push_beat(256, 1, 0); // prob row, tie
      push_beat(-1, 0, 0); push_beat(-2, 0, 0); push_beat(-1, 0, 1);
      push_beat(5, 0, 1);                                  // empty summary
      push_beat(10, 0, 0); push_beat(-4000, 0, 0); push_beat(4095, 0, 0);
      push_beat(-32768, 0, 0); push_beat(16'h5555, 0, 0);
      push_beat(-21846, 1, 1);
      wait_drained();

      // ceiling sequence: wait out every result before going on
      push_sequence(3, 6);
      wait_drained();

      csr_write(16'h0000);
      push_sequence(4, 4);
      wait_drained();
      csr_write(16'd3);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 17 : 78) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 17 : 78) : 0;
         for (int n = 0; n < 380; ) begin
            if ($urandom_range(9) == 0) begin
               push_beat($urandom_range(65535) - 32768, 1'($urandom_range(1)),
                         1'($urandom_range(1)));
               n++;
            end else begin
               int rows, cls;
               rows = $urandom_range(1, 5);
               cls  = $urandom_range(2, 8);
               push_sequence(rows, cls);
               n += rows * cls;
            end
         end
         wait_drained();
         send_idle_pct = 0; recv_stall_pct = 0;
         csr_write(phase == 0 ? 16'hFFFF : phase == 1 ? 16'd1 : 16'd5);
      end

      // one long row that saturates nothing but reaches wide class indexes
      push_sequence(1, 40);
      wait_drained();

      $display("covered %0d score beats and %0d result beats over four idle mixes",
               sent_beats, got_results);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
